>>> rtl/core/utf_pkg.sv
// ----------------------------------------------------------------------------
// utf_pkg
// Shared types, constants and character mapping functions for the UUID text formatter.
// ----------------------------------------------------------------------------
package utf_pkg;

    localparam int TEXT_MAX       = 36;
    localparam int HEX_DIGITS     = 32;
    localparam int BASE62_DIGITS  = 11;
    localparam int HALF_W         = 64;
    localparam int B62_BITS_STEP  = 2;
    localparam int B62_SHIFT_STEPS = HALF_W / B62_BITS_STEP;
    localparam int B62_DONE       = B62_SHIFT_STEPS + BASE62_DIGITS;
    localparam int CNT_W          = $clog2(B62_DONE + 1);
    localparam int LEN_W          = $clog2(TEXT_MAX + 1);

    localparam logic [LEN_W-1:0] LEN_HYPHEN = LEN_W'(TEXT_MAX);
    localparam logic [LEN_W-1:0] LEN_PLAIN  = LEN_W'(HEX_DIGITS);
    localparam logic [LEN_W-1:0] LEN_B62    = LEN_W'(2 * BASE62_DIGITS);

    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_LA   = 8'h61;
    localparam logic [7:0] CH_UA   = 8'h41;
    localparam logic [7:0] CH_DASH = 8'h2D;

    typedef enum logic [1:0] {
        MODE_HYPHEN = 2'd0,
        MODE_PLAIN  = 2'd1,
        MODE_B62    = 2'd2,
        MODE_OFF    = 2'd3
    } t_mode;

    typedef logic [TEXT_MAX-1:0][7:0] t_text;

    typedef struct packed {
        logic full;
        logic done;
    } t_cv_status;

    typedef struct packed {
        logic       valid;
        logic       last;
        logic [7:0] code;
    } t_slot;

    function automatic logic [7:0] f_hex_char(input logic [3:0] i_nib);
        logic [7:0] w_v;
        w_v = {4'd0, i_nib};
        return (w_v < 8'd10) ? (CH_ZERO + w_v) : (CH_LA + w_v - 8'd10);
    endfunction

    function automatic logic [7:0] f_b62_char(input logic [5:0] i_dig);
        logic [7:0] w_v;
        w_v = {2'd0, i_dig};
        if (w_v < 8'd10) begin
            return CH_ZERO + w_v;
        end else if (w_v < 8'd36) begin
            return CH_LA + w_v - 8'd10;
        end else begin
            return CH_UA + w_v - 8'd36;
        end
    endfunction

endpackage

>>> rtl/core/utf_b62_cell.sv
// ----------------------------------------------------------------------------
// utf_b62_cell
// One base-62 digit cell: multiplies its digit and the incoming carry by
// four, adds the bits (flush: just the carry), carry out to the next cell.
// ----------------------------------------------------------------------------
module utf_b62_cell (
    input  logic       i_clk,
    input  logic       i_clr,
    input  logic       i_en,
    input  logic       i_flush,
    input  logic [2:0] i_cin,
    input  logic [1:0] i_bits,
    output logic [5:0] o_digit,
    output logic [2:0] o_carry
);
    logic [5:0] r_digit, n_digit;
    logic [2:0] r_carry, n_carry;
    logic [8:0] w_sum;

    always_comb begin
        if (i_flush) begin
            w_sum = {3'd0, r_digit} + {6'd0, i_cin};
        end else begin
            w_sum = {1'b0, r_digit, 2'b00} + {4'd0, i_cin, 2'b00} + {7'd0, i_bits};
        end
        if (w_sum >= 9'd248) begin
            n_carry = 3'd4;
            n_digit = 6'(w_sum - 9'd248);
        end else if (w_sum >= 9'd186) begin
            n_carry = 3'd3;
            n_digit = 6'(w_sum - 9'd186);
        end else if (w_sum >= 9'd124) begin
            n_carry = 3'd2;
            n_digit = 6'(w_sum - 9'd124);
        end else if (w_sum >= 9'd62) begin
            n_carry = 3'd1;
            n_digit = 6'(w_sum - 9'd62);
        end else begin
            n_carry = 3'd0;
            n_digit = 6'(w_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_clr) begin
            r_digit <= '0;
            r_carry <= '0;
        end else if (i_en) begin
            r_digit <= n_digit;
            r_carry <= n_carry;
        end
    end

    assign o_digit = r_digit;
    assign o_carry = r_carry;

endmodule

>>> rtl/core/utf_text_cell.sv
// ----------------------------------------------------------------------------
// utf_text_cell
// One character slot of the output chain. It loads a character in parallel
// or takes the one held by its neighbor further from the head.
// ----------------------------------------------------------------------------
module utf_text_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  logic           i_shift,
    input  utf_pkg::t_slot i_ld,
    input  utf_pkg::t_slot i_next,
    output utf_pkg::t_slot o_slot
);
    import utf_pkg::*;

    logic       r_valid;
    logic       r_last;
    logic [7:0] r_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_ld.valid;
        end else if (i_shift) begin
            r_valid <= i_next.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_last <= i_ld.last;
            r_code <= i_ld.code;
        end else if (i_shift) begin
            r_last <= i_next.last;
            r_code <= i_next.code;
        end
    end

    assign o_slot = '{valid: r_valid, last: r_last, code: r_code};

endmodule

>>> rtl/core/utf_convert.sv
// ----------------------------------------------------------------------------
// utf_convert
// Holds one UUID and renders its text: hex directly, base-62 through two
// chains of digit cells fed two bits per cycle and then flushed.
// ----------------------------------------------------------------------------
module utf_convert (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_take,
    input  logic                i_release,
    input  utf_pkg::t_mode      i_mode,
    input  logic [63:0]         i_hi,
    input  logic [63:0]         i_lo,
    output utf_pkg::t_cv_status o_status,
    output utf_pkg::t_text      o_text,
    output logic [5:0]          o_len
);
    import utf_pkg::*;

    logic             r_full;
    t_mode            r_mode;
    logic [CNT_W-1:0] r_cnt;
    logic [63:0]      r_hi, r_lo;
    logic             w_step, w_flush;

    logic [5:0] w_dig_hi [BASE62_DIGITS];
    logic [5:0] w_dig_lo [BASE62_DIGITS];
    logic [2:0] w_car_hi [BASE62_DIGITS];
    logic [2:0] w_car_lo [BASE62_DIGITS];

    assign w_step  = r_full && (r_mode == MODE_B62) && (r_cnt < CNT_W'(B62_DONE));
    assign w_flush = (r_cnt >= CNT_W'(B62_SHIFT_STEPS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else if (i_take) begin
            r_full <= (i_mode != MODE_OFF);
        end else if (i_release) begin
            r_full <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_mode <= i_mode;
            r_cnt  <= '0;
            r_hi   <= i_hi;
            r_lo   <= i_lo;
        end else if (w_step) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (!w_flush) begin
                r_hi <= {r_hi[61:0], 2'b00};
                r_lo <= {r_lo[61:0], 2'b00};
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < BASE62_DIGITS; g++) begin : g_cell
            if (g == 0) begin : g_head
                utf_b62_cell u_hi (
                    .i_clk   (i_clk),
                    .i_clr   (i_take),
                    .i_en    (w_step),
                    .i_flush (w_flush),
                    .i_cin   (3'd0),
                    .i_bits  (w_flush ? 2'b00 : r_hi[63:62]),
                    .o_digit (w_dig_hi[g]),
                    .o_carry (w_car_hi[g])
                );
                utf_b62_cell u_lo (
                    .i_clk   (i_clk),
                    .i_clr   (i_take),
                    .i_en    (w_step),
                    .i_flush (w_flush),
                    .i_cin   (3'd0),
                    .i_bits  (w_flush ? 2'b00 : r_lo[63:62]),
                    .o_digit (w_dig_lo[g]),
                    .o_carry (w_car_lo[g])
                );
            end else begin : g_body
                utf_b62_cell u_hi (
                    .i_clk   (i_clk),
                    .i_clr   (i_take),
                    .i_en    (w_step),
                    .i_flush (w_flush),
                    .i_cin   (w_car_hi[g-1]),
                    .i_bits  (2'b00),
                    .o_digit (w_dig_hi[g]),
                    .o_carry (w_car_hi[g])
                );
                utf_b62_cell u_lo (
                    .i_clk   (i_clk),
                    .i_clr   (i_take),
                    .i_en    (w_step),
                    .i_flush (w_flush),
                    .i_cin   (w_car_lo[g-1]),
                    .i_bits  (2'b00),
                    .o_digit (w_dig_lo[g]),
                    .o_carry (w_car_lo[g])
                );
            end
        end
    endgenerate

    always_comb begin
        o_text = '0;
        o_len  = LEN_HYPHEN;
        case (r_mode)
            MODE_HYPHEN: begin
                for (int d = 0; d < HEX_DIGITS; d++) begin
                    o_text[d + (d >= 8) + (d >= 12) + (d >= 16) + (d >= 20)] =
                        (d < 16) ? f_hex_char(r_hi[63 - 4 * d -: 4])
                                 : f_hex_char(r_lo[63 - 4 * (d - 16) -: 4]);
                end
                o_text[8]  = CH_DASH;
                o_text[13] = CH_DASH;
                o_text[18] = CH_DASH;
                o_text[23] = CH_DASH;
                o_len = LEN_HYPHEN;
            end
            MODE_PLAIN: begin
                for (int d = 0; d < HEX_DIGITS; d++) begin
                    o_text[d] = (d < 16) ? f_hex_char(r_hi[63 - 4 * d -: 4])
                                         : f_hex_char(r_lo[63 - 4 * (d - 16) -: 4]);
                end
                o_len = LEN_PLAIN;
            end
            MODE_B62: begin
                for (int k = 0; k < BASE62_DIGITS; k++) begin
                    o_text[k] = f_b62_char(w_dig_hi[BASE62_DIGITS - 1 - k]);
                    o_text[BASE62_DIGITS + k] = f_b62_char(w_dig_lo[BASE62_DIGITS - 1 - k]);
                end
                o_len = LEN_B62;
            end
            default: begin
                o_len = LEN_HYPHEN;
            end
        endcase
    end

    assign o_status = '{full: r_full,
                        done: r_full && ((r_mode != MODE_B62) ||
                                         (r_cnt == CNT_W'(B62_DONE)))};

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full |-> (r_cnt <= CNT_W'(B62_DONE)))
        else $error("base-62 step counter ran past the flush end");

    a_flush_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_status.done && (r_mode == MODE_B62)) |->
            ((w_car_hi[BASE62_DIGITS-1] == 3'd0) && (w_car_lo[BASE62_DIGITS-1] == 3'd0)
             && (w_car_hi[0] == 3'd0) && (w_car_lo[0] == 3'd0)))
        else $error("base-62 carries still pending when the text was released");

    a_release_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_release |-> o_status.done)
        else $error("text released before conversion finished");

endmodule

>>> rtl/core/uuid_text_format.sv
// ----------------------------------------------------------------------------
// uuid_text_format
// Renders a 128-bit UUID as ASCII text, one character per output transaction,
// in hyphenated hex, plain hex or two-half base-62; off mode drops the UUID.
//
// Channel   Dir  Handshake                  Payload
// s_axis    in   s_axis_tvalid/tready       tdata[63:0] uuid_high, [127:64] uuid_low
// m_axis    out  m_axis_tvalid/tready       tdata[7:0] char_code, tlast last_char
// cfg       in   i_cfg_valid/o_cfg_ready    i_cfg_data[1:0] format_mode
//
// Hex modes stream UUIDs back to back with no gap; the 36-cell character chain
// holds the text of one UUID.
// Base-62 loads a UUID, then runs two-bit steps and carry flush steps in the
// digit-cell chains, during which the previous text drains.
// A new UUID is taken while the previous text still streams; s_axis_tready
// drops while a held UUID is still converting or waits for the chain to empty.
// Reset is synchronous and clears the mode register and all valid state.
// ----------------------------------------------------------------------------
module uuid_text_format (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    input  logic [127:0]   s_axis_tdata,   // uuid_high, uuid_low
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    output logic [7:0]     m_axis_tdata,   // char_code
    output logic           m_axis_tlast,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [1:0]     i_cfg_data
);
    import utf_pkg::*;

    t_mode      r_format_mode;
    t_cv_status w_status;
    t_text      w_text;
    logic [5:0] w_len;
    logic       w_take, w_load, w_shift, w_empty_next;
    t_slot      w_slot [TEXT_MAX];
    t_slot      w_ld   [TEXT_MAX];
    logic [TEXT_MAX-1:0] w_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format_mode <= MODE_HYPHEN;
        end else if (i_cfg_valid) begin
            r_format_mode <= t_mode'(i_cfg_data);
        end
    end

    assign o_cfg_ready = 1'b1;

    always_comb begin
        for (int p = 0; p < TEXT_MAX; p++) begin
            w_valid[p]    = w_slot[p].valid;
            w_ld[p].valid = (LEN_W'(p) < w_len);
            w_ld[p].last  = (LEN_W'(p + 1) == w_len);
            w_ld[p].code  = w_text[p];
        end
    end

    assign w_shift      = !w_valid[0] || m_axis_tready;
    assign w_empty_next = (w_valid[TEXT_MAX-1:1] == '0) && w_shift;
    assign w_load       = w_status.done && w_empty_next;
    assign s_axis_tready = !w_status.full || w_load;
    assign w_take       = s_axis_tvalid && s_axis_tready;

    utf_convert u_convert (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (w_take),
        .i_release (w_load),
        .i_mode    (r_format_mode),
        .i_hi      (s_axis_tdata[63:0]),
        .i_lo      (s_axis_tdata[127:64]),
        .o_status  (w_status),
        .o_text    (w_text),
        .o_len     (w_len)
    );

    genvar g;
    generate
        for (g = 0; g < TEXT_MAX; g++) begin : g_text
            utf_text_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_load  (w_load),
                .i_shift (w_shift),
                .i_ld    (w_ld[g]),
                .i_next  ((g == TEXT_MAX - 1) ? t_slot'('0) : w_slot[(g + 1) % TEXT_MAX]),
                .o_slot  (w_slot[g])
            );
        end
    endgenerate

    assign m_axis_tvalid = w_slot[0].valid;
    assign m_axis_tdata  = w_slot[0].code;
    assign m_axis_tlast  = w_slot[0].last;

    a_last_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_slot[0].valid && w_slot[0].last) |-> (w_valid[TEXT_MAX-1:1] == '0))
        else $error("characters queued behind the final character of a UUID");

    a_take_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && w_status.full) |-> w_load)
        else $error("UUID taken over one that was not yet handed to the chain");

    a_load_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (w_valid[0] == (w_len != 6'd0)) || !w_valid[0])
        else $error("character chain head inconsistent after a load");

endmodule
